// ----- sv/triangle_element_matrices_unit_macros.svh -----
// Assertion macros for the triangle element matrices unit.
`ifndef TRIANGLE_ELEMENT_MATRICES_UNIT_MACROS_SVH
`define TRIANGLE_ELEMENT_MATRICES_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define TEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
// Next-cycle implication check.
`define TEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define TEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/tem_pkg.sv -----
// Types and constants shared by the triangle element matrices unit.
package tem_pkg;

	localparam int CoordW    = 24;
	localparam int JacW      = 25;
	localparam int ProdW     = 49;
	localparam int SumW      = 50;
	localparam int MagW      = 49;
	localparam int OutW      = 48;
	localparam int QuoW      = 48;
	localparam int NumShift  = 24;
	localparam int DivSteps  = 48;
	localparam int ByteW     = 8;
	localparam int Div3Bytes = 7;
	localparam int Div3W     = 56;
	localparam int NumG      = 7;

	// numerator slots; the determinant rides in the last one
	localparam logic [2:0] G00    = 3'd0;
	localparam logic [2:0] G01    = 3'd1;
	localparam logic [2:0] G02    = 3'd2;
	localparam logic [2:0] G11    = 3'd3;
	localparam logic [2:0] G12    = 3'd4;
	localparam logic [2:0] G22    = 3'd5;
	localparam logic [2:0] DetIdx = 3'd6;

	localparam logic [1:0] LastIdx = 2'd2;

	localparam int LumpShift  = 9;
	localparam int MdiagShift = 10;
	localparam int MoffShift  = 11;
	localparam int AreaShift  = 9;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [JacW-1:0]   jac_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [SumW-1:0]   sum_t;
	typedef logic signed [OutW-1:0]   q24_t;

	typedef struct packed {
		logic            neg;
		logic [MagW-1:0] mag;
	} sm_t;

	typedef struct packed {
		logic             det_zero;
		sm_t              det;
		sm_t [5:0]        g;
		logic [1:0]       rem3;
		logic [Div3W-1:0] sh3;
		logic [Div3W-1:0] quo3;
	} item_t;

	typedef struct packed {
		logic [1:0]      row;
		logic [1:0]      col;
		logic            last;
		logic            degen;
		logic            sneg;
		logic            sat;
		logic            dneg;
		logic [MagW-1:0] dmag;
		logic [MagW-1:0] rem;
		logic [QuoW-1:0] lo;
		logic [OutW-1:0] mass;
		logic [OutW-1:0] lumped;
		logic [OutW-1:0] area;
	} div_t;

	typedef struct packed {
		logic [1:0] row_index;
		logic [1:0] col_index;
		q24_t       stiffness;
		q24_t       mass;
		q24_t       lumped;
		q24_t       area;
		logic       degenerate;
		logic       last;
	} out_t;

endpackage

// ----- sv/tem_if.sv -----
// Stream interfaces for triangle words in and matrix entry words out.
interface tem_in_if
	import tem_pkg::*;
();
	logic   valid;
	logic   ready;
	coord_t x_first;
	coord_t y_first;
	coord_t x_second;
	coord_t y_second;
	coord_t x_third;
	coord_t y_third;

	modport source(output valid, x_first, y_first, x_second, y_second, x_third, y_third,
		input ready);
	modport sink(input valid, x_first, y_first, x_second, y_second, x_third, y_third,
		output ready);
endinterface

interface tem_out_if
	import tem_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] row_index;
	logic [1:0] col_index;
	q24_t       stiffness;
	q24_t       mass;
	q24_t       lumped;
	q24_t       area;
	logic       degenerate;
	logic       last;

	modport source(output valid, row_index, col_index, stiffness, mass, lumped, area,
		degenerate, last, input ready);
	modport sink(input valid, row_index, col_index, stiffness, mass, lumped, area,
		degenerate, last, output ready);
endinterface

// ----- sv/triangle_element_matrices_unit.sv -----
// Top level: P1 triangle stiffness and mass matrix pipeline.
//
// channel   dir  word
// tri_in    in   three vertices of one triangle, Q8.16
// mat_out   out  one matrix entry (row, col), Q24.24, nine per triangle
//
// A triangle passes 4 arithmetic stages, 7 divide-by-3 stages, the entry
// sequencer, 48 quotient stages and the output register before its first word.
// The sequencer issues one entry a cycle unless mat_out stalls.
// Reset clears all valid bits and the sequencer; payload registers are not reset.
// A stall at mat_out freezes the whole pipeline; no word is dropped or repeated.
`include "triangle_element_matrices_unit_macros.svh"
module triangle_element_matrices_unit
	import tem_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	tem_in_if.sink     tri_in,
	tem_out_if.source  mat_out
);

	// multiply two Jacobian terms at full product width
	function automatic prod_t mul(jac_t a, jac_t b);
		prod_t ea;
		prod_t eb;
		ea = ProdW'(a);
		eb = ProdW'(b);
		return ea * eb;
	endfunction

	function automatic sm_t to_sm(sum_t v, logic flip);
		sm_t s;
		s.neg = v[SumW-1] ^ flip;
		s.mag = v[SumW-1] ? MagW'(-v) : MagW'(v);
		return s;
	endfunction

	// one byte of long division by three
	function automatic item_t d3_step(item_t x);
		item_t      y;
		logic [1:0] r;
		logic [2:0] t;
		logic [ByteW-1:0] q;
		y = x;
		r = x.rem3;
		q = '0;
		for (int i = ByteW - 1; i >= 0; i--) begin
			t = {r, x.sh3[Div3W-ByteW+i]};
			if (t >= 3'd3) begin
				r = 2'(t - 3'd3);
				q[i] = 1'b1;
			end else begin
				r = t[1:0];
			end
		end
		y.rem3 = r;
		y.sh3 = {x.sh3[Div3W-ByteW-1:0], {ByteW{1'b0}}};
		y.quo3 = {x.quo3[Div3W-ByteW-1:0], q};
		return y;
	endfunction

	// one quotient bit of restoring division
	function automatic div_t div_step(div_t x);
		div_t          y;
		logic [MagW:0] r2;
		logic          ge;
		y = x;
		r2 = {x.rem, x.lo[QuoW-1]};
		ge = r2 >= {1'b0, x.dmag};
		y.rem = ge ? MagW'(r2 - {1'b0, x.dmag}) : MagW'(r2);
		y.lo = {x.lo[QuoW-2:0], ge};
		return y;
	endfunction

	function automatic logic [2:0] gsel(logic [1:0] r, logic [1:0] c);
		logic [2:0] k;
		case ({r, c})
			4'b0000: k = G00;
			4'b0001, 4'b0100: k = G01;
			4'b0010, 4'b1000: k = G02;
			4'b0101: k = G11;
			4'b0110, 4'b1001: k = G12;
			default: k = G22;
		endcase
		return k;
	endfunction

	logic adv, front_adv, seq_take, seq_last;

	logic v_s1, v_s2, v_s3, v_s4;
	jac_t j0_s1, j1_s1, j2_s1, j3_s1, d0_s1, d2_s1;
	prod_t pa_s2 [NumG];
	prod_t pb_s2 [NumG];
	sum_t  s_s3 [NumG];
	item_t it_s4, it_d;
	item_t d3_s [Div3Bytes];
	logic  d3_v_s [Div3Bytes];

	item_t      seq_q;
	logic       seq_v_q;
	logic [1:0] row_q, col_q;

	div_t dv_in;
	div_t div_s [DivSteps];
	logic div_v_s [DivSteps];

	out_t out_d, out_q;
	logic out_v_q;
	logic out_at_last;

	// global advance; the front also waits for the sequencer
	assign adv = !out_v_q || mat_out.ready;
	assign seq_last = (row_q == LastIdx) && (col_q == LastIdx);
	assign seq_take = !seq_v_q || seq_last;
	assign front_adv = adv && seq_take;
	assign tri_in.ready = front_adv;

	// advance front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < Div3Bytes; i++) d3_v_s[i] <= 1'b0;
		end else if (front_adv) begin
			v_s1 <= tri_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			d3_v_s[0] <= v_s4;
			for (int i = 1; i < Div3Bytes; i++) d3_v_s[i] <= d3_v_s[i-1];
		end
	end

	// form the stage 4 word: magnitudes and signs
	always_comb begin
		it_d = '0;
		for (int k = 0; k < 6; k++) begin
			it_d.g[k] = to_sm(s_s3[k], (3'(k) == G02) || (3'(k) == G12));
		end
		it_d.det = to_sm(s_s3[DetIdx], 1'b0);
		it_d.det_zero = (s_s3[DetIdx] == '0);
		it_d.sh3 = Div3W'(it_d.det.mag);
	end

	// front payload: differences, products, sums, magnitudes, divide by three
	always_ff @(posedge clk) begin
		if (front_adv) begin
			j0_s1 <= JacW'(tri_in.x_second) - JacW'(tri_in.x_first);
			j1_s1 <= JacW'(tri_in.x_third) - JacW'(tri_in.x_first);
			j2_s1 <= JacW'(tri_in.y_second) - JacW'(tri_in.y_first);
			j3_s1 <= JacW'(tri_in.y_third) - JacW'(tri_in.y_first);
			d0_s1 <= JacW'(tri_in.x_second) - JacW'(tri_in.x_third);
			d2_s1 <= JacW'(tri_in.y_second) - JacW'(tri_in.y_third);

			pa_s2[G00] <= mul(d0_s1, d0_s1);
			pb_s2[G00] <= mul(d2_s1, d2_s1);
			pa_s2[G01] <= mul(d0_s1, j1_s1);
			pb_s2[G01] <= mul(d2_s1, j3_s1);
			pa_s2[G02] <= mul(j0_s1, d0_s1);
			pb_s2[G02] <= mul(j2_s1, d2_s1);
			pa_s2[G11] <= mul(j1_s1, j1_s1);
			pb_s2[G11] <= mul(j3_s1, j3_s1);
			pa_s2[G12] <= mul(j0_s1, j1_s1);
			pb_s2[G12] <= mul(j2_s1, j3_s1);
			pa_s2[G22] <= mul(j0_s1, j0_s1);
			pb_s2[G22] <= mul(j2_s1, j2_s1);
			pa_s2[DetIdx] <= mul(j0_s1, j3_s1);
			pb_s2[DetIdx] <= mul(j1_s1, j2_s1);

			for (int k = 0; k < 6; k++) begin
				s_s3[k] <= SumW'(pa_s2[k]) + SumW'(pb_s2[k]);
			end
			s_s3[DetIdx] <= SumW'(pa_s2[DetIdx]) - SumW'(pb_s2[DetIdx]);

			it_s4 <= it_d;

			d3_s[0] <= d3_step(it_s4);
			for (int i = 1; i < Div3Bytes; i++) d3_s[i] <= d3_step(d3_s[i-1]);

			seq_q <= d3_s[Div3Bytes-1];
		end
	end

	// step the entry sequencer in row-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end else if (adv) begin
			if (seq_take) begin
				seq_v_q <= d3_v_s[Div3Bytes-1];
				row_q <= '0;
				col_q <= '0;
			end else if (col_q == LastIdx) begin
				col_q <= '0;
				row_q <= row_q + 2'd1;
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	// build the divider entry word and the rounded mass, lumped and area terms
	always_comb begin
		logic [2:0]      gi;
		sm_t             num;
		logic [QuoW-1:0] a;
		gi = gsel(row_q, col_q);
		num = seq_q.g[gi];
		a = seq_q.quo3[QuoW-1:0];
		dv_in.row = row_q;
		dv_in.col = col_q;
		dv_in.last = seq_last;
		dv_in.degen = seq_q.det_zero;
		dv_in.sneg = num.neg ^ seq_q.det.neg;
		dv_in.dneg = seq_q.det.neg;
		dv_in.dmag = seq_q.det.mag;
		dv_in.rem = MagW'(num.mag[MagW-1:NumShift]);
		dv_in.sat = MagW'(num.mag[MagW-1:NumShift]) >= seq_q.det.mag;
		dv_in.lo = {num.mag[NumShift-1:0], {(QuoW-NumShift){1'b0}}};
		dv_in.lumped = OutW'(({1'b0, a} + ((QuoW+1)'(1) << (LumpShift - 1))) >> LumpShift);
		if (row_q == col_q) begin
			dv_in.mass = OutW'(({1'b0, a} + ((QuoW+1)'(1) << (MdiagShift - 1)))
				>> MdiagShift);
		end else begin
			dv_in.mass = OutW'(({1'b0, a} + ((QuoW+1)'(1) << (MoffShift - 1))) >> MoffShift);
		end
		dv_in.area = OutW'(({1'b0, seq_q.det.mag} + ((MagW+1)'(1) << (AreaShift - 1)))
			>> AreaShift);
	end

	// advance divider valid bits and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DivSteps; i++) div_v_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			div_v_s[0] <= seq_v_q;
			for (int i = 1; i < DivSteps; i++) div_v_s[i] <= div_v_s[i-1];
			out_v_q <= div_v_s[DivSteps-1];
		end
	end

	// round, saturate and sign the finished word
	always_comb begin
		div_t          f;
		logic [QuoW:0] rnd;
		logic          big;
		f = div_s[DivSteps-1];
		rnd = ({1'b0, f.lo} + (QuoW+1)'(1)) >> 1;
		big = f.sat || rnd[OutW-1];
		out_d.row_index = f.row;
		out_d.col_index = f.col;
		out_d.degenerate = f.degen;
		out_d.last = f.last;
		if (f.degen) begin
			out_d.stiffness = '0;
		end else if (big) begin
			out_d.stiffness = f.sneg ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
		end else begin
			out_d.stiffness = f.sneg ? -OutW'(rnd) : OutW'(rnd);
		end
		out_d.mass = f.dneg ? -f.mass : f.mass;
		out_d.lumped = f.dneg ? -f.lumped : f.lumped;
		out_d.area = f.dneg ? -f.area : f.area;
	end

	// divider payload and output word
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_step(dv_in);
			for (int i = 1; i < DivSteps; i++) div_s[i] <= div_step(div_s[i-1]);
			out_q <= out_d;
		end
	end

	assign mat_out.valid = out_v_q;
	assign mat_out.row_index = out_q.row_index;
	assign mat_out.col_index = out_q.col_index;
	assign mat_out.stiffness = out_q.stiffness;
	assign mat_out.mass = out_q.mass;
	assign mat_out.lumped = out_q.lumped;
	assign mat_out.area = out_q.area;
	assign mat_out.degenerate = out_q.degenerate;
	assign mat_out.last = out_q.last;

	// output word sits on the bottom right entry
	assign out_at_last = (out_q.row_index == LastIdx) && (out_q.col_index == LastIdx);

	`TEM_ASSERT_IMP(a_last_pos, clk, arst_n, out_v_q && out_q.last, out_at_last)
	`TEM_ASSERT_IMP(a_not_last, clk, arst_n, out_v_q && !out_q.last, !out_at_last)
	`TEM_ASSERT_IMP(a_degen_zero, clk, arst_n, out_v_q && out_q.degenerate, out_q.stiffness == '0)
	`TEM_ASSERT_IMP(a_seq_range, clk, arst_n, seq_v_q, row_q != 2'd3 && col_q != 2'd3)
	`TEM_ASSERT_NEXT(a_enter, clk, arst_n, tri_in.valid && tri_in.ready, v_s1)

endmodule
